// ----- hw/rtl/g6d_pkg.sv -----
// ----------------------------------------------------------------------------
// g6d_pkg: shared types and constants for the graph6 edge decoder
// Request layouts between the front and back ends, result layout and codes.
// ----------------------------------------------------------------------------
package g6d_pkg;

  localparam int VtxW        = 6;
  localparam int CharW       = 8;
  localparam int BitsPerChar = 6;
  localparam int SeenW       = 9;
  localparam int QueueDepth  = 2;

  localparam logic [CharW-1:0] CharBias = 8'd63;
  localparam logic [CharW-1:0] CharTop  = 8'd126;
  localparam logic [SeenW-1:0] SeenMax  = 9'd511;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_CHAR  = 2'd1,
    STAT_BIG_COUNT = 2'd2,
    STAT_BAD_LEN   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_EDGE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // One request from front to back: an optional six-bit walk, then an
  // optional closing status.
  typedef struct packed {
    logic                   walk;
    logic [BitsPerChar-1:0] bits;
    logic [VtxW-1:0]        n;
    logic                   stat_en;
    status_e                status;
  } cmd_t;

  typedef struct packed {
    kind_e           kind;
    logic [VtxW-1:0] lo;
    logic [VtxW-1:0] hi;
    logic [VtxW-1:0] cnt;
    status_e         status;
    logic            last;
  } res_t;

  typedef logic [SeenW-1:0] chars_tab_t [2**VtxW];

  // Expected number of data characters for each vertex count.
  function automatic chars_tab_t build_chars_tab();
    chars_tab_t tab;
    int         pairs;
    for (int n = 0; n < 2**VtxW; n++) begin
      pairs  = (n > 0) ? (n * (n - 1)) / 2 : 0;
      tab[n] = SeenW'((pairs + 5) / 6);
    end
    return tab;
  endfunction

endpackage

// ----- hw/rtl/g6d_queue.sv -----
// ----------------------------------------------------------------------------
// g6d_queue: short request queue between front and back ends
// Register-based FIFO of cmd_t entries.
// ----------------------------------------------------------------------------
module g6d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  g6d_pkg::cmd_t  wr_data_i,
  input  logic           rd_i,
  output g6d_pkg::cmd_t  rd_data_o,
  output logic           full_o,
  output logic           empty_o
);
  import g6d_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hw/rtl/g6d_front.sv -----
// ----------------------------------------------------------------------------
// g6d_front: character intake and line bookkeeping
// Classifies each character, tracks count, length and error, issues requests.
// ----------------------------------------------------------------------------
module g6d_front #(
  parameter int MaxVertices = 62
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [g6d_pkg::CharW-1:0]   char_code_i,
  input  logic                        line_end_i,
  input  logic                        q_full_i,
  output logic                        cmd_wr_o,
  output g6d_pkg::cmd_t               cmd_o
);
  import g6d_pkg::*;

  localparam chars_tab_t CharsTab = build_chars_tab();
  localparam logic [CharW-1:0] MaxCnt = CharW'(MaxVertices);

  logic                at_start_q, at_start_d;
  logic [VtxW-1:0]     n_q, n_d;
  logic [SeenW-1:0]    seen_q, seen_d;
  status_e             err_q, err_d;

  logic                accept;
  logic                char_ok;
  logic [CharW-1:0]    v;
  logic [VtxW-1:0]     n_now;
  logic [SeenW-1:0]    seen_now;
  status_e             err_now;
  logic                walk;

  assign full    = q_full_i;
  assign accept  = push && !q_full_i;
  assign char_ok = (char_code_i >= CharBias) && (char_code_i <= CharTop);
  assign v       = char_code_i - CharBias;

  always_comb begin
    n_now    = n_q;
    seen_now = seen_q;
    err_now  = err_q;
    walk     = 1'b0;
    if (at_start_q) begin
      seen_now = '0;
      if (!char_ok) begin
        err_now = STAT_BAD_CHAR;
        n_now   = '0;
      end else if (v > MaxCnt) begin
        err_now = STAT_BIG_COUNT;
        n_now   = '0;
      end else begin
        err_now = STAT_OK;
        n_now   = v[VtxW-1:0];
      end
    end else begin
      if (seen_q != SeenMax) begin
        seen_now = seen_q + 1'b1;
      end
      if (!char_ok) begin
        err_now = STAT_BAD_CHAR;
      end
      walk = (err_now == STAT_OK);
    end
  end

  always_comb begin
    cmd_o.walk    = walk;
    cmd_o.bits    = v[BitsPerChar-1:0];
    cmd_o.n       = n_now;
    cmd_o.stat_en = line_end_i;
    cmd_o.status  = err_now;
    if ((err_now == STAT_OK) && (seen_now != CharsTab[n_now])) begin
      cmd_o.status = STAT_BAD_LEN;
    end
  end

  assign cmd_wr_o = accept && (walk || line_end_i);

  always_comb begin
    at_start_d = at_start_q;
    n_d        = n_q;
    seen_d     = seen_q;
    err_d      = err_q;
    if (accept) begin
      if (line_end_i) begin
        at_start_d = 1'b1;
        n_d        = '0;
        seen_d     = '0;
        err_d      = STAT_OK;
      end else begin
        at_start_d = 1'b0;
        n_d        = n_now;
        seen_d     = seen_now;
        err_d      = err_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      n_q        <= '0;
      seen_q     <= '0;
      err_q      <= STAT_OK;
    end else begin
      at_start_q <= at_start_d;
      n_q        <= n_d;
      seen_q     <= seen_d;
      err_q      <= err_d;
    end
  end

endmodule

// ----- hw/rtl/g6d_back.sv -----
// ----------------------------------------------------------------------------
// g6d_back: bit walker and result register
// Steps one adjacency bit per cycle over the upper triangle, a set bit waiting
// for room; edges and the closing status go into a single output register.
// ----------------------------------------------------------------------------
module g6d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  g6d_pkg::cmd_t  cmd_i,
  input  logic           q_empty_i,
  output logic           q_rd_o,
  input  logic           pop,
  output logic           empty,
  output g6d_pkg::res_t  res_o
);
  import g6d_pkg::*;

  localparam int WalkW = $clog2(BitsPerChar + 1);
  localparam logic [WalkW-1:0] WalkLen = WalkW'(BitsPerChar);

  logic [WalkW-1:0]       walk_cnt_q, walk_cnt_d;
  logic [BitsPerChar-1:0] bits_q, bits_d;
  logic [VtxW-1:0]        n_q, n_d;
  logic                   stat_pend_q, stat_pend_d;
  status_e                stat_q, stat_d;
  logic [VtxW-1:0]        row_q, row_d;
  logic [VtxW-1:0]        col_q, col_d;
  logic                   out_valid_q, out_valid_d;
  res_t                   out_q, out_d;

  logic                   out_free;
  logic                   in_range;
  logic                   hit;
  logic                   emit;
  res_t                   res;

  assign out_free = !out_valid_q || pop;
  assign in_range = (col_q < n_q);
  assign hit      = bits_q[BitsPerChar-1] && in_range;

  always_comb begin
    walk_cnt_d  = walk_cnt_q;
    bits_d      = bits_q;
    n_d         = n_q;
    stat_pend_d = stat_pend_q;
    stat_d      = stat_q;
    row_d       = row_q;
    col_d       = col_q;
    emit        = 1'b0;
    res         = '0;
    q_rd_o      = 1'b0;

    if (walk_cnt_q != '0) begin
      if (!hit || out_free) begin
        if (hit) begin
          emit      = 1'b1;
          res.kind  = KIND_EDGE;
          res.lo    = row_q;
          res.hi    = col_q;
        end
        // advance along the column; past the triangle the position holds
        if (in_range) begin
          if ((row_q + 1'b1) != col_q) begin
            row_d = row_q + 1'b1;
          end else begin
            row_d = '0;
            col_d = col_q + 1'b1;
          end
        end
        bits_d     = {bits_q[BitsPerChar-2:0], 1'b0};
        walk_cnt_d = walk_cnt_q - 1'b1;
      end
    end else if (stat_pend_q) begin
      if (out_free) begin
        emit        = 1'b1;
        res.kind    = KIND_STATUS;
        res.cnt     = n_q;
        res.status  = stat_q;
        res.last    = 1'b1;
        row_d       = '0;
        col_d       = VtxW'(1);
        stat_pend_d = 1'b0;
      end
    end

    // take the next request as soon as the current one is finished
    if ((walk_cnt_d == '0) && !stat_pend_d && !q_empty_i) begin
      q_rd_o      = 1'b1;
      walk_cnt_d  = cmd_i.walk ? WalkLen : '0;
      bits_d      = cmd_i.bits;
      n_d         = cmd_i.n;
      stat_pend_d = cmd_i.stat_en;
      stat_d      = cmd_i.status;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  assign empty = !out_valid_q;
  assign res_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_cnt_q  <= '0;
      stat_pend_q <= 1'b0;
      row_q       <= '0;
      col_q       <= VtxW'(1);
      out_valid_q <= 1'b0;
    end else begin
      walk_cnt_q  <= walk_cnt_d;
      stat_pend_q <= stat_pend_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    n_q    <= n_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

endmodule

// ----- hw/rtl/graph6_edge_decoder.sv -----
// ----------------------------------------------------------------------------
// graph6_edge_decoder: short-form graph6 line to edge list
// Front end classifies characters, back end walks the adjacency bits.
// ----------------------------------------------------------------------------
// Feed one graph6 line a character per request, line_end_i set on the last
// one. The first character (minus 63) is the vertex count, up to MaxVertices;
// every later character carries six adjacency bits, MSB first, over the upper
// triangle in column order. Each set bit comes out in order as an edge result
// (kind 0, low/high vertex); padding bits are dropped. The last character is
// followed by a status result (kind 1, last 1) with the count and status:
// ok, bad character, oversized count or wrong length. Discard the line's
// edges if the status is not ok.
// Timing: the front end takes a character every cycle while its two-entry
// request queue has room. The back end spends one cycle per adjacency bit,
// stalling on a set bit while its single output register holds an unpopped
// result, and takes the next request only once the current one, its status
// included, is finished; the sustained character rate is set by this bit
// walker. Characters that produce no work (count character, characters after
// an error) write no request to the queue unless they end the line.
module graph6_edge_decoder #(
  parameter int MaxVertices = 62
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [g6d_pkg::CharW-1:0]   char_code_i,
  input  logic                        line_end_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind_o,
  output logic [g6d_pkg::VtxW-1:0]    low_vertex_o,
  output logic [g6d_pkg::VtxW-1:0]    high_vertex_o,
  output logic [g6d_pkg::VtxW-1:0]    num_vertices_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);
  import g6d_pkg::*;

  cmd_t cmd_wr_data;
  cmd_t cmd_rd_data;
  logic cmd_wr;
  logic cmd_rd;
  logic q_full;
  logic q_empty;
  res_t res;

  // Front: line state, error priority and length check.
  g6d_front #(
    .MaxVertices (MaxVertices)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_code_i (char_code_i),
    .line_end_i  (line_end_i),
    .q_full_i    (q_full),
    .cmd_wr_o    (cmd_wr),
    .cmd_o       (cmd_wr_data)
  );

  // Decoupling queue between the two halves.
  g6d_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_wr),
    .wr_data_i (cmd_wr_data),
    .rd_i      (cmd_rd),
    .rd_data_o (cmd_rd_data),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // Back: triangle walk and result register.
  g6d_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_rd_data),
    .q_empty_i (q_empty),
    .q_rd_o    (cmd_rd),
    .pop       (pop),
    .empty     (empty),
    .res_o     (res)
  );

  assign kind_o         = res.kind;
  assign low_vertex_o   = res.lo;
  assign high_vertex_o  = res.hi;
  assign num_vertices_o = res.cnt;
  assign status_o       = res.status;
  assign last_o         = res.last;

endmodule
